@@ rtl/i2cms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// shared codes and types of the i2c master transfer sequencer
// no dependencies; used by the step logic, the top level and the checker
package i2cms_pkg;

  // operation codes of an input word
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  // transfer phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ADDR   = 3'd1;
  localparam logic [2:0] PH_SUB    = 3'd2;
  localparam logic [2:0] PH_RSTART = 3'd3;
  localparam logic [2:0] PH_WRITE  = 3'd4;
  localparam logic [2:0] PH_READ   = 3'd5;

  // bus actions
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_SEND   = 3'd2;
  localparam logic [2:0] ACT_RSTART = 3'd3;
  localparam logic [2:0] ACT_RECV   = 3'd4;
  localparam logic [2:0] ACT_STOP   = 3'd5;

  // completion status
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_ARB     = 3'd2;
  localparam logic [2:0] ST_NAK     = 3'd3;
  localparam logic [2:0] ST_ADDRNAK = 3'd4;

  // longest subaddress in bytes
  localparam logic [2:0] SUB_MAX = 3'd4;

  typedef struct packed {
    logic [2:0]  phase;
    logic [6:0]  target_address;
    logic        reading;
    logic [31:0] pending_subaddress;
    logic [2:0]  subaddress_left;
    logic [15:0] data_left;
  } seq_state_t;

  typedef struct packed {
    logic        operation;
    logic [6:0]  slave_address;
    logic        read_not_write;
    logic [31:0] subaddress;
    logic [2:0]  subaddress_bytes;
    logic [15:0] data_count;
    logic        bus_busy;
    logic        arbitration_lost;
    logic        no_ack;
    logic [7:0]  received_byte;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       nak_next;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [2:0] status;
    logic       done_res;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/i2cms_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channel interfaces: begin/event words in, bus decision words out
// depends on nothing but the port widths of the sequencer
interface i2cms_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [6:0]  slave_address;
  logic        read_not_write;
  logic [31:0] subaddress;
  logic [2:0]  subaddress_bytes;
  logic [15:0] data_count;
  logic        bus_busy;
  logic        arbitration_lost;
  logic        no_ack;
  logic [7:0]  received_byte;
  logic [7:0]  write_byte;

  modport source (
    output valid, operation, slave_address, read_not_write, subaddress, subaddress_bytes,
           data_count, bus_busy, arbitration_lost, no_ack, received_byte, write_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, slave_address, read_not_write, subaddress, subaddress_bytes,
           data_count, bus_busy, arbitration_lost, no_ack, received_byte, write_byte,
    output ready
  );
endinterface

interface i2cms_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_action;
  logic [7:0] tx_byte;
  logic       nak_next;
  logic       read_valid;
  logic [7:0] read_byte;
  logic [2:0] status;
  logic       done_res;

  modport source (
    output valid, bus_action, tx_byte, nak_next, read_valid, read_byte, status, done_res,
    input  ready
  );
  modport sink (
    input  valid, bus_action, tx_byte, nak_next, read_valid, read_byte, status, done_res,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/i2c_master_transfer_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// top level of the i2c master transfer sequencer: state register and output word register
// depends on i2cms_pkg, i2cms_ifs (i2cms_req_if, i2cms_rsp_if) and i2cms_step
//
//   channel | dir | word contents
//   --------+-----+-----------------------------------------------------------------
//   req     | in  | begin (address, direction, subaddress, count, busy) or byte-done
//           |     | event (arbitration lost, no ack, received byte, next write byte)
//   rsp     | out | bus action, tx byte, nak for next byte, read byte, status, done
//
// every req word gives exactly one rsp word, in the cycle after it is taken
// one word per cycle while rsp is not stalled: the state update and the decision are one pass of i2cms_step
// req.ready is high whenever the output register is empty or drains in the same cycle
// a stalled rsp holds its word and holds off req; no other back pressure
// synchronous active-high reset returns the sequencer to idle with an empty output
module i2c_master_transfer_sequencer (
  input  wire           clk,
  input  wire           rst,
  i2cms_req_if.sink     req,
  i2cms_rsp_if.source   rsp
);
  import i2cms_pkg::*;

  seq_state_t state;
  seq_state_t state_next;
  item_t      item;
  result_t    result;
  result_t    result_next;
  logic       out_valid;
  logic       accept;

  // gather the incoming word
  assign item.operation        = req.operation;
  assign item.slave_address    = req.slave_address;
  assign item.read_not_write   = req.read_not_write;
  assign item.subaddress       = req.subaddress;
  assign item.subaddress_bytes = req.subaddress_bytes;
  assign item.data_count       = req.data_count;
  assign item.bus_busy         = req.bus_busy;
  assign item.arbitration_lost = req.arbitration_lost;
  assign item.no_ack           = req.no_ack;
  assign item.received_byte    = req.received_byte;
  assign item.write_byte       = req.write_byte;

  // take a new word when the output slot is free or being emptied
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  i2cms_step u_step (
    .cur  (state),
    .item (item),
    .nxt  (state_next),
    .res  (result_next)
  );

  // transfer state, moves only on a taken word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{PH_IDLE, 7'd0, 1'b0, 32'd0, 3'd0, 16'd0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.bus_action = result.bus_action;
  assign rsp.tx_byte    = result.tx_byte;
  assign rsp.nak_next   = result.nak_next;
  assign rsp.read_valid = result.read_valid;
  assign rsp.read_byte  = result.read_byte;
  assign rsp.status     = result.status;
  assign rsp.done_res   = result.done_res;

endmodule
`default_nettype wire

@@ rtl/i2cms_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// next-state and result logic for one begin or byte-done word
// depends on i2cms_pkg
module i2cms_step (
  input  i2cms_pkg::seq_state_t cur,
  input  i2cms_pkg::item_t      item,
  output i2cms_pkg::seq_state_t nxt,
  output i2cms_pkg::result_t    res
);
  import i2cms_pkg::*;

  logic [15:0] dl_dec;
  logic [2:0]  sl_dec;
  logic [2:0]  sub_n;
  logic        dirbit;
  logic [7:0]  sub_byte;
  seq_state_t  sd_state;
  result_t     sd_res;

  assign dl_dec = cur.data_left - 16'd1;
  assign sl_dec = cur.subaddress_left - 3'd1;
  assign sub_n  = (item.subaddress_bytes > SUB_MAX) ? SUB_MAX : item.subaddress_bytes;
  assign dirbit = (item.read_not_write && sub_n != 3'd0) ? 1'b0 : item.read_not_write;

  // subaddress goes out high byte first
  always_comb begin
    unique case (sl_dec[1:0])
      2'd0:    sub_byte = cur.pending_subaddress[7:0];
      2'd1:    sub_byte = cur.pending_subaddress[15:8];
      2'd2:    sub_byte = cur.pending_subaddress[23:16];
      default: sub_byte = cur.pending_subaddress[31:24];
    endcase
  end

  // entry into the data phase, or a stop when no data bytes are left
  always_comb begin
    sd_state = cur;
    sd_res   = '0;
    if (cur.data_left == 16'd0) begin
      sd_state.phase  = PH_IDLE;
      sd_res.bus_action = ACT_STOP;
      sd_res.status   = ST_OK;
      sd_res.done_res = 1'b1;
    end else if (cur.reading) begin
      sd_state.phase    = PH_READ;
      sd_res.bus_action = ACT_RECV;
      sd_res.nak_next   = (cur.data_left == 16'd1);
    end else begin
      sd_state.phase     = PH_WRITE;
      sd_state.data_left = dl_dec;
      sd_res.bus_action  = ACT_SEND;
      sd_res.tx_byte     = item.write_byte;
    end
  end

  always_comb begin
    nxt = cur;
    res = '0;
    if (item.operation == OP_BEGIN) begin
      if (cur.phase == PH_IDLE) begin
        if (item.bus_busy) begin
          res.status   = ST_BUSY;
          res.done_res = 1'b1;
        end else begin
          nxt.phase              = PH_ADDR;
          nxt.target_address     = item.slave_address;
          nxt.reading            = item.read_not_write;
          nxt.pending_subaddress = item.subaddress;
          nxt.subaddress_left    = sub_n;
          nxt.data_left          = item.data_count;
          res.bus_action         = ACT_START;
          res.tx_byte            = {item.slave_address, dirbit};
        end
      end
    end else begin
      unique case (cur.phase)
        PH_ADDR, PH_SUB, PH_WRITE: begin
          priority if (item.arbitration_lost) begin
            nxt.phase      = PH_IDLE;
            res.bus_action = ACT_STOP;
            res.status     = ST_ARB;
            res.done_res   = 1'b1;
          end else if (item.no_ack) begin
            nxt.phase      = PH_IDLE;
            res.bus_action = ACT_STOP;
            res.status     = ST_NAK;
            res.done_res   = 1'b1;
          end else if (cur.phase == PH_WRITE) begin
            nxt = sd_state;
            res = sd_res;
          end else if (cur.subaddress_left != 3'd0) begin
            nxt.subaddress_left = sl_dec;
            nxt.phase           = PH_SUB;
            res.bus_action      = ACT_SEND;
            res.tx_byte         = sub_byte;
          end else if (cur.phase == PH_SUB && cur.reading) begin
            nxt.phase      = PH_RSTART;
            res.bus_action = ACT_RSTART;
            res.tx_byte    = {cur.target_address, 1'b1};
          end else begin
            nxt = sd_state;
            res = sd_res;
          end
        end
        PH_RSTART: begin
          if (item.arbitration_lost || item.no_ack) begin
            nxt.phase      = PH_IDLE;
            res.bus_action = ACT_STOP;
            res.status     = ST_ADDRNAK;
            res.done_res   = 1'b1;
          end else begin
            nxt = sd_state;
            res = sd_res;
          end
        end
        PH_READ: begin
          if (item.arbitration_lost) begin
            nxt.phase      = PH_IDLE;
            res.bus_action = ACT_STOP;
            res.status     = ST_ARB;
            res.done_res   = 1'b1;
          end else begin
            nxt.data_left  = dl_dec;
            res.read_valid = 1'b1;
            res.read_byte  = item.received_byte;
            if (dl_dec == 16'd0) begin
              nxt.phase      = PH_IDLE;
              res.bus_action = ACT_STOP;
              res.done_res   = 1'b1;
            end else begin
              res.bus_action = ACT_RECV;
              res.nak_next   = (dl_dec == 16'd1);
            end
          end
        end
        default: begin
          // idle or unused phase code: event ignored
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/i2cms_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// port-level checker for the i2c master transfer sequencer, bound to the top level
// depends on i2cms_pkg
module i2cms_props (
  input wire       clk,
  input wire       rst,
  input wire       req_valid,
  input wire       req_ready,
  input wire       rsp_valid,
  input wire       rsp_ready,
  input wire [2:0] bus_action,
  input wire [7:0] tx_byte,
  input wire       nak_next,
  input wire       read_valid,
  input wire [7:0] read_byte
);
  import i2cms_pkg::*;

  // a taken word shows up on rsp next cycle
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted word gave no result");

  // an empty output slot never holds off req
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("req stalled with empty output");

  // a stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(bus_action) && $stable(tx_byte))
    else $error("stalled result dropped or changed");

  // nak only goes with a receive
  a_nak_recv: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && nak_next |-> bus_action == ACT_RECV)
    else $error("nak without receive");

  // no read byte without its flag, no tx byte without a send
  a_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (!read_valid && read_byte != 8'd0 ||
    tx_byte != 8'd0 && bus_action != ACT_START && bus_action != ACT_SEND &&
    bus_action != ACT_RSTART) |-> 1'b0)
    else $error("stray payload bits");

endmodule

bind i2c_master_transfer_sequencer i2cms_props u_i2cms_props (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .bus_action (rsp.bus_action),
  .tx_byte    (rsp.tx_byte),
  .nak_next   (rsp.nak_next),
  .read_valid (rsp.read_valid),
  .read_byte  (rsp.read_byte)
);
`default_nettype wire
